>>> rtl/core/dve_pkg.sv
// ----------------------------------------------------------------------------
// Delta varint encoder package
// Item kind codes, stream constants and the control and status structs that
// pass between the sequencer and the byte unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dve_pkg;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_WORD  = 2'd1;
   localparam logic [1:0] KIND_TAIL  = 2'd2;

   localparam logic [7:0]  RECORD_MARK  = 8'd5;
   localparam logic [63:0] SMALL_RECORD = 64'd8;
   localparam logic [3:0]  WORD_BYTES   = 4'd8;
   localparam logic [3:0]  ONE_BYTE     = 4'd1;

   typedef struct packed {
      logic        load;
      logic        shift;
      logic        raw_mode;
      logic [63:0] value;
      logic [3:0]  count;
   } unit_ctrl_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } unit_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/dve_ifs.sv
// ----------------------------------------------------------------------------
// Delta varint encoder channels
// Valid/ready channels for input items and for encoded output bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dve_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] item_data;

   modport source (output valid, output kind, output item_data, input ready);
   modport sink   (input valid, input kind, input item_data, output ready);
endinterface

interface dve_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/core/delta_varint_encoder.sv
// ----------------------------------------------------------------------------
// Delta varint encoder
// Encodes records as a marker, a varint size, varint word deltas and raw
// tail bytes, one output byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// The first output byte is valid in the cycle after the input is taken. An
// item yields 0 to 11 bytes, none for an unused kind or a start below
// SMALL_RECORD, whose words then pass raw. No new item is taken until the
// last byte of the current one is out. Synchronous reset clears the sequencer,
// the previous word, the first-word flag and the pass-through flag.
`default_nettype none

module delta_varint_encoder
   import dve_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   dve_req_if.sink   req_ch,
   dve_rsp_if.source rsp_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MARK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [63:0]   prev_ff, prev_in;
   logic          have_first_ff, have_first_in;
   logic          pass_ff, pass_in;
   logic          req_fire, rsp_fire;
   unit_ctrl_type ctrl;
   unit_stat_type stat;

   assign req_fire      = req_ch.valid && req_ch.ready;
   assign rsp_fire      = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = (state_ff == ST_MARK) || (state_ff == ST_EMIT);
   assign rsp_ch.out_byte    = (state_ff == ST_MARK) ? RECORD_MARK : stat.data;
   assign rsp_ch.last_of_run = (state_ff == ST_MARK) ? 1'b0 : stat.last;

   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      have_first_in = have_first_ff;
      pass_in       = pass_ff;
      ctrl.load     = 1'b0;
      ctrl.shift    = 1'b0;
      ctrl.raw_mode = 1'b0;
      ctrl.value    = req_ch.item_data;
      ctrl.count    = WORD_BYTES;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.kind)
                  KIND_START: begin
                     prev_in       = '0;
                     have_first_in = 1'b0;
                     pass_in       = (req_ch.item_data < SMALL_RECORD);
                     ctrl.load     = 1'b1;
                     if (req_ch.item_data >= SMALL_RECORD) begin
                        state_in = ST_MARK;
                     end
                  end
                  KIND_WORD: begin
                     ctrl.load = 1'b1;
                     state_in  = ST_EMIT;
                     if (pass_ff) begin
                        ctrl.raw_mode = 1'b1;
                     end else begin
                        if (have_first_ff) begin
                           ctrl.value = req_ch.item_data - prev_ff;
                        end
                        prev_in       = req_ch.item_data;
                        have_first_in = 1'b1;
                     end
                  end
                  KIND_TAIL: begin
                     ctrl.load     = 1'b1;
                     ctrl.raw_mode = 1'b1;
                     ctrl.count    = ONE_BYTE;
                     state_in      = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MARK: begin
            if (rsp_fire) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               ctrl.shift = 1'b1;
               if (stat.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_ff       <= '0;
         have_first_ff <= 1'b0;
         pass_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         have_first_ff <= have_first_in;
         pass_ff       <= pass_in;
      end
   end

   dve_byte_unit u_byte_unit (
      .clock (clock),
      .ctrl  (ctrl),
      .stat  (stat)
   );

endmodule

`default_nettype wire

>>> rtl/core/dve_byte_unit.sv
// ----------------------------------------------------------------------------
// Delta varint encoder byte unit
// Holds the value being emitted and peels off one byte per step, either as
// a seven-bit LEB128 group or as a raw byte with a down counter.
// ----------------------------------------------------------------------------
`default_nettype none

module dve_byte_unit
   import dve_pkg::*;
(
   input  wire logic          clock,
   input  wire unit_ctrl_type ctrl,
   output unit_stat_type      stat
);

   logic [63:0] value_ff, value_in;
   logic [3:0]  count_ff, count_in;
   logic        raw_ff, raw_in;
   logic        more;

   assign more = |value_ff[63:7];

   always_comb begin
      value_in = value_ff;
      count_in = count_ff;
      raw_in   = raw_ff;
      if (ctrl.load) begin
         value_in = ctrl.value;
         count_in = ctrl.count;
         raw_in   = ctrl.raw_mode;
      end else if (ctrl.shift) begin
         if (raw_ff) begin
            value_in = {8'd0, value_ff[63:8]};
            count_in = count_ff - ONE_BYTE;
         end else begin
            value_in = {7'd0, value_ff[63:7]};
         end
      end
   end

   always_comb begin
      if (raw_ff) begin
         stat.data = value_ff[7:0];
         stat.last = (count_ff == ONE_BYTE);
      end else begin
         stat.data = {more, value_ff[6:0]};
         stat.last = !more;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      count_ff <= count_in;
      raw_ff   <= raw_in;
   end

endmodule

`default_nettype wire
